[src/blpc_pkg.sv]
package blpc_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_ERROR      = 3'd2;
  localparam logic [2:0] ST_LEN_BAD    = 3'd3;
  localparam logic [2:0] ST_CRC_BAD    = 3'd4;

  localparam logic [1:0] CFG_VERIFY    = 2'd0;
  localparam logic [1:0] CFG_TEXT      = 2'd1;
  localparam logic [1:0] CFG_CHARS     = 2'd2;
  localparam logic [1:0] CFG_FORMAT    = 2'd3;

  localparam logic [7:0] LEAD_END      = 8'd254;
  localparam logic [7:0] LEAD_ERROR    = 8'd255;
  localparam logic [31:0] HEADER_LEN   = 32'd27;
  localparam logic [31:0] VERSION_AT   = 32'd29;

  typedef enum logic [1:0] {
    VC_EQUAL      = 2'd0,
    VC_LESS       = 2'd1,
    VC_GREATER    = 2'd2,
    VC_DONE_EQUAL = 2'd3
  } vcmp_t;

  typedef struct packed {
    logic [7:0]   lead;
    logic [191:0] hdr;
    logic [31:0]  pos;
    logic [31:0]  crc;
    logic [31:0]  tail;
    vcmp_t        vcmp;
  } pkt_sum_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] stamp;
    logic [7:0]  event_kind;
    logic [31:0] origin_server;
    logic [31:0] body_length;
    logic [31:0] next_position;
    logic [15:0] event_flag_bits;
    logic        checksums_active;
    logic [15:0] server_error_code;
    logic [15:0] warning_total;
    logic [15:0] server_state_bits;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[src/blpc_front.sv]
module blpc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_fire,
  input  logic [7:0]              packet_byte,
  input  logic                    end_of_packet,
  input  logic [63:0]             ver_text,
  input  logic [3:0]              ver_chars,
  output logic                    sum_valid,
  output blpc_pkg::pkt_sum_t      sum
);
  import blpc_pkg::*;

  logic [31:0]  pos;
  logic [7:0]   lead;
  logic [191:0] hdr;
  logic [31:0]  crc;
  logic [31:0]  tail;
  vcmp_t        vcmp;

  logic [31:0]  pos_next;
  logic [7:0]   lead_next;
  logic [191:0] hdr_next;
  logic [31:0]  crc_next;
  logic [31:0]  tail_next;
  vcmp_t        vcmp_next;
  logic [31:0]  e;
  logic [31:0]  k;
  logic [7:0]   c;

  always_comb begin
    e = pos - 32'd1;
    k = e - VERSION_AT;
    c = ver_text[{k[2:0], 3'b000} +: 8];
    if (k[31:3] != 29'd0) begin
      c = 8'd0;
    end
    lead_next = lead;
    hdr_next  = hdr;
    crc_next  = crc;
    tail_next = tail;
    vcmp_next = vcmp;
    if (pos == 32'd0) begin
      lead_next = packet_byte;
      hdr_next  = '0;
      crc_next  = '1;
      tail_next = '0;
      vcmp_next = VC_EQUAL;
    end else begin
      if (e < 32'd24) begin
        hdr_next[{e[4:0], 3'b000} +: 8] = packet_byte;
      end
      if (pos >= 32'd5) begin
        crc_next = crc_byte(crc, tail[7:0]);
      end
      tail_next = {packet_byte, tail[31:8]};
      if (vcmp == VC_EQUAL && e >= VERSION_AT && k < {28'd0, ver_chars}) begin
        if (packet_byte < c) begin
          vcmp_next = VC_LESS;
        end else if (packet_byte > c) begin
          vcmp_next = VC_GREATER;
        end else if (packet_byte == 8'd0) begin
          vcmp_next = VC_DONE_EQUAL;
        end
      end
    end
    pos_next = (pos != '1) ? pos + 32'd1 : pos;
    if (end_of_packet) begin
      pos_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      lead      <= '0;
      hdr       <= '0;
      crc       <= '1;
      tail      <= '0;
      vcmp      <= VC_EQUAL;
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= in_fire && end_of_packet;
      if (in_fire) begin
        pos  <= pos_next;
        lead <= lead_next;
        hdr  <= hdr_next;
        crc  <= crc_next;
        tail <= tail_next;
        vcmp <= vcmp_next;
        sum  <= '{lead: lead_next, hdr: hdr_next, pos: pos, crc: crc_next,
                  tail: tail_next, vcmp: vcmp_next};
      end
    end
  end

endmodule

[src/blpc_back.sv]
module blpc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sum_valid,
  input  blpc_pkg::pkt_sum_t      sum,
  input  logic                    verify_crc,
  input  logic [7:0]              format_code,
  output logic                    res_valid,
  output blpc_pkg::result_t       res
);
  import blpc_pkg::*;

  logic    checksum_mode;
  logic    mode_next;
  result_t r;
  logic [31:0] len;
  logic [31:0] body;
  logic [31:0] crcv;

  always_comb begin
    len  = sum.hdr[72 +: 32];
    r    = '0;
    body = '0;
    mode_next = checksum_mode;
    crcv = (sum.pos >= 32'd4) ? ~sum.crc : 32'd0;
    if (sum.pos == 32'd4 && sum.lead == LEAD_END) begin
      r.status = ST_END;
      r.checksums_active = checksum_mode;
      r.warning_total = sum.hdr[15:0];
      r.server_state_bits = sum.hdr[31:16];
    end else if (sum.lead == LEAD_ERROR) begin
      r.status = ST_ERROR;
      r.checksums_active = checksum_mode;
      r.server_error_code = sum.hdr[15:0];
    end else begin
      r.stamp = sum.hdr[31:0];
      r.event_kind = sum.hdr[39:32];
      r.origin_server = sum.hdr[71:40];
      r.next_position = sum.hdr[135:104];
      r.event_flag_bits = sum.hdr[151:136];
      r.status = ST_OK;
      if (len != sum.pos) begin
        r.status = ST_LEN_BAD;
      end else begin
        if (len > HEADER_LEN) begin
          body = len - HEADER_LEN;
          if (sum.hdr[39:32] == format_code && sum.vcmp != VC_GREATER) begin
            mode_next = 1'b1;
          end
          if (mode_next) begin
            body = (body >= 32'd4) ? body - 32'd4 : 32'd0;
          end
        end
        if (mode_next && verify_crc && crcv != sum.tail) begin
          r.status = ST_CRC_BAD;
        end
      end
      r.body_length = body;
      r.checksums_active = mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      checksum_mode <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      res_valid <= sum_valid;
      if (sum_valid) begin
        checksum_mode <= mode_next;
        res <= r;
      end
    end
  end

endmodule

[src/blpc_fifo.sv]
module blpc_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  blpc_pkg::result_t       din,
  input  logic                    pop,
  output logic                    not_empty,
  output logic [2:0]              count,
  output blpc_pkg::result_t       dout
);
  import blpc_pkg::*;

  result_t     mem [4];
  logic [1:0]  wp;
  logic [1:0]  rp;
  logic [2:0]  cnt;

  assign not_empty = cnt != 3'd0;
  assign dout = mem[rp];
  assign count = cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        mem[wp] <= din;
        wp <= wp + 2'd1;
      end
      if (pop) begin
        rp <= rp + 2'd1;
      end
      cnt <= cnt + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

[src/binlog_event_packet_checker_unit.sv]
// Binlog reply packet checker. One packet byte is taken per cycle while
// in_ready is high, with end_of_packet on the last byte; a packet's result is
// registered in the front and back stages, then queued. The front stage's
// byte-wide CRC-32 step sets that rate. A four-entry result queue absorbs
// output stalls; in_ready drops when queued plus in-flight results reach four.
// Configuration is taken at any time, intended while no packet is in flight.
module binlog_event_packet_checker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  packet_byte,
  input  logic        end_of_packet,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] stamp,
  output logic [7:0]  event_kind,
  output logic [31:0] origin_server,
  output logic [31:0] body_length,
  output logic [31:0] next_position,
  output logic [15:0] event_flag_bits,
  output logic        checksums_active,
  output logic [15:0] server_error_code,
  output logic [15:0] warning_total,
  output logic [15:0] server_state_bits
);
  import blpc_pkg::*;

  logic        verify_crc;
  logic [63:0] ver_text;
  logic [3:0]  ver_chars;
  logic [7:0]  format_code;
  logic        in_fire;
  logic        sum_valid;
  pkt_sum_t    sum;
  logic        res_valid;
  result_t     res;
  logic        q_ne;
  logic [2:0]  q_cnt;
  result_t     q_out;
  logic        pop;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign pop = q_ne && out_ready;
  assign in_ready = ({1'b0, q_cnt} + {3'd0, sum_valid} + {3'd0, res_valid}) < 4'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      verify_crc  <= 1'b0;
      ver_text    <= '0;
      ver_chars   <= 4'd5;
      format_code <= 8'd15;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VERIFY: verify_crc  <= cfg_data[0];
        CFG_TEXT:   ver_text    <= cfg_data;
        CFG_CHARS:  ver_chars   <= cfg_data[3:0];
        CFG_FORMAT: format_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  blpc_front u_front (
    .clk, .rst, .in_fire, .packet_byte, .end_of_packet,
    .ver_text, .ver_chars, .sum_valid, .sum
  );

  blpc_back u_back (
    .clk, .rst, .sum_valid, .sum, .verify_crc, .format_code, .res_valid, .res
  );

  blpc_fifo u_fifo (
    .clk, .rst, .push(res_valid), .din(res), .pop,
    .not_empty(q_ne), .count(q_cnt), .dout(q_out)
  );

  assign out_valid         = q_ne;
  assign status            = q_out.status;
  assign stamp             = q_out.stamp;
  assign event_kind        = q_out.event_kind;
  assign origin_server     = q_out.origin_server;
  assign body_length       = q_out.body_length;
  assign next_position     = q_out.next_position;
  assign event_flag_bits   = q_out.event_flag_bits;
  assign checksums_active  = q_out.checksums_active;
  assign server_error_code = q_out.server_error_code;
  assign warning_total     = q_out.warning_total;
  assign server_state_bits = q_out.server_state_bits;

endmodule

[src/blpc_checker.sv]
module blpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [15:0] server_error_code,
  input logic [15:0] warning_total
);
  import blpc_pkg::*;

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_CRC_BAD) else $error("status out of range");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ERROR |-> server_error_code == 16'd0)
    else $error("error code without error");

  a_warn_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_END |-> warning_total == 16'd0)
    else $error("warnings without end marker");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");

endmodule

bind binlog_event_packet_checker_unit blpc_checker u_blpc_checker (
  .clk, .rst, .out_valid, .out_ready,
  .status, .server_error_code, .warning_total
);

[dv/binlog_event_packet_checker_unit_test.sv]
`timescale 1ns / 1ps

module binlog_event_packet_checker_unit_test;
  import blpc_pkg::*;

  class packet_scoreboard;
    bit          verify_on;
    logic [63:0] version_text;
    logic [3:0]  version_chars;
    logic [7:0]  format_code;
    logic [31:0] pos;
    logic [7:0]  lead;
    logic [191:0] hdr;
    logic [31:0] crc;
    logic [31:0] tail;
    vcmp_t       vcmp;
    bit          cks_mode;
    result_t     pending[$];
    int          errors;

    function new();
      verify_on = 0;
      version_text = '0;
      version_chars = 4'd5;
      format_code = 8'd15;
      pos = '0;
      lead = '0;
      hdr = '0;
      crc = 32'hFFFFFFFF;
      tail = '0;
      vcmp = VC_EQUAL;
      cks_mode = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        CFG_VERIFY: verify_on = val[0];
        CFG_TEXT:   version_text = val;
        CFG_CHARS:  version_chars = val[3:0];
        CFG_FORMAT: format_code = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] hfield(int first, int count);
      logic [31:0] v;
      v = '0;
      for (int k = 0; k < count; k++) v[8*k +: 8] = hdr[8*(first+k) +: 8];
      return v;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) r = (r >> 1) ^ (32'hEDB88320 & {32{r[0]}});
      return r;
    endfunction

    function void note_byte(logic [7:0] b, bit eop);
      logic [31:0] p;
      logic [31:0] e;
      logic [31:0] k;
      logic [7:0]  c;
      logic [31:0] len;
      logic [31:0] body;
      logic [31:0] sum;
      result_t     r;
      p = pos;
      if (p == 0) begin
        lead = b;
        hdr = '0;
        crc = 32'hFFFFFFFF;
        tail = '0;
        vcmp = VC_EQUAL;
      end else begin
        e = p - 1;
        if (e < 24) hdr[8*e +: 8] = b;
        if (p >= 5) crc = crc_step(crc, tail[7:0]);
        tail = {b, tail[31:8]};
        if (vcmp == VC_EQUAL && e >= 29 && e - 29 < {28'd0, version_chars}) begin
          k = e - 29;
          c = (k < 8) ? version_text[8*k +: 8] : 8'd0;
          if (b < c) vcmp = VC_LESS;
          else if (b > c) vcmp = VC_GREATER;
          else if (b == 0) vcmp = VC_DONE_EQUAL;
        end
      end
      if (p != 32'hFFFFFFFF) pos = p + 1;
      if (!eop) return;
      pos = 0;
      r = '0;
      if (p == 4 && lead == LEAD_END) begin
        r.status = ST_END;
        r.checksums_active = cks_mode;
        r.warning_total = hfield(0, 2);
        r.server_state_bits = hfield(2, 2);
      end else if (lead == LEAD_ERROR) begin
        r.status = ST_ERROR;
        r.checksums_active = cks_mode;
        r.server_error_code = hfield(0, 2);
      end else begin
        len = hfield(9, 4);
        body = 0;
        r.status = ST_OK;
        r.stamp = hfield(0, 4);
        r.event_kind = hdr[39:32];
        r.origin_server = hfield(5, 4);
        r.next_position = hfield(13, 4);
        r.event_flag_bits = hfield(17, 2);
        if (len != p) r.status = ST_LEN_BAD;
        else begin
          if (len > 27) begin
            body = len - 27;
            if (hdr[39:32] == format_code && vcmp != VC_GREATER) cks_mode = 1;
            if (cks_mode) body = (body >= 4) ? body - 4 : 0;
          end
          if (cks_mode && verify_on) begin
            sum = (p >= 4) ? ~crc : 32'd0;
            if (sum != tail) r.status = ST_CRC_BAD;
          end
        end
        r.body_length = body;
        r.checksums_active = cks_mode;
      end
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (w.status != got.status) begin
        $display("%0t: status exp %0d got %0d", $time, w.status, got.status); errors++;
      end
      if (w.stamp != got.stamp) begin
        $display("%0t: stamp exp %h got %h", $time, w.stamp, got.stamp); errors++;
      end
      if (w.event_kind != got.event_kind) begin
        $display("%0t: event_kind exp %h got %h", $time, w.event_kind, got.event_kind);
        errors++;
      end
      if (w.origin_server != got.origin_server) begin
        $display("%0t: origin_server exp %h got %h", $time, w.origin_server,
                 got.origin_server); errors++;
      end
      if (w.body_length != got.body_length) begin
        $display("%0t: body_length exp %0d got %0d", $time, w.body_length,
                 got.body_length); errors++;
      end
      if (w.next_position != got.next_position) begin
        $display("%0t: next_position exp %h got %h", $time, w.next_position,
                 got.next_position); errors++;
      end
      if (w.event_flag_bits != got.event_flag_bits) begin
        $display("%0t: event_flag_bits exp %h got %h", $time, w.event_flag_bits,
                 got.event_flag_bits); errors++;
      end
      if (w.checksums_active != got.checksums_active) begin
        $display("%0t: checksums_active exp %0d got %0d", $time, w.checksums_active,
                 got.checksums_active); errors++;
      end
      if (w.server_error_code != got.server_error_code) begin
        $display("%0t: server_error_code exp %h got %h", $time, w.server_error_code,
                 got.server_error_code); errors++;
      end
      if (w.warning_total != got.warning_total) begin
        $display("%0t: warning_total exp %h got %h", $time, w.warning_total,
                 got.warning_total); errors++;
      end
      if (w.server_state_bits != got.server_state_bits) begin
        $display("%0t: server_state_bits exp %h got %h", $time, w.server_state_bits,
                 got.server_state_bits); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  packet_byte;
  logic        end_of_packet;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        out_valid;
  logic        out_ready;
  result_t     got;

  packet_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int byte_count;

  binlog_event_packet_checker_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .packet_byte(packet_byte), .end_of_packet(end_of_packet),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(got.status), .stamp(got.stamp), .event_kind(got.event_kind),
    .origin_server(got.origin_server), .body_length(got.body_length),
    .next_position(got.next_position), .event_flag_bits(got.event_flag_bits),
    .checksums_active(got.checksums_active),
    .server_error_code(got.server_error_code),
    .warning_total(got.warning_total), .server_state_bits(got.server_state_bits)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("binlog_event_packet_checker_unit_test: errors");
    $finish;
  end

  // receiver side
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(got);
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_byte(logic [7:0] b, bit eop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    packet_byte <= b;
    end_of_packet <= eop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, eop);
    byte_count++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    in_valid <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_packet(logic [7:0] pkt[]);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // builds an event packet; good length when good_len is set, trailer when cks is set, valid when good_crc is set
  task automatic send_event(logic [7:0] kind, int body, bit cks, bit good_len,
                            bit good_crc, logic [63:0] ver, int ver_len);
    logic [7:0]  pkt[];
    int          n;
    logic [31:0] len;
    logic [31:0] c;
    n = 19 + body + (cks ? 4 : 0);
    pkt = new[n + 1];
    pkt[0] = (($urandom_range(9) == 0) ? 8'd254 : 8'd0);
    for (int i = 1; i <= n; i++) pkt[i] = 8'($urandom);
    len = good_len ? n : $urandom;
    pkt[5] = kind;
    for (int k = 0; k < 4; k++) pkt[10+k] = len[8*k +: 8];
    for (int k = 0; k < ver_len && 30 + k <= n; k++)
      pkt[30+k] = (k < 8) ? ver[8*k +: 8] : 8'd0;
    if (cks) begin
      c = 32'hFFFFFFFF;
      for (int i = 1; i <= n - 4; i++) c = sb.crc_step(c, pkt[i]);
      c = ~c;
      if (!good_crc) c ^= 32'h1 << $urandom_range(31);
      for (int k = 0; k < 4; k++) pkt[n-3+k] = c[8*k +: 8];
    end
    send_packet(pkt);
  endtask

  task automatic random_config();
    write_reg(CFG_VERIFY, 64'($urandom_range(3) != 0));
    write_reg(CFG_TEXT, {$urandom, $urandom});
    write_reg(CFG_CHARS, 64'($urandom_range(15)));
    write_reg(CFG_FORMAT, ($urandom_range(1)) ? 64'd15 : 64'($urandom_range(255)));
  endtask

  task automatic random_traffic(int target);
    int sel;
    int start;
    logic [7:0] pkt[];
    start = byte_count;
    while (byte_count - start < target) begin
      sel = $urandom_range(99);
      if (sel < 55)
        send_event(($urandom_range(2) == 0) ? sb.format_code : 8'($urandom),
                   ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(14),
                   sb.cks_mode || $urandom_range(1), $urandom_range(9) != 0,
                   $urandom_range(4) != 0, sb.version_text, $urandom_range(9));
      else if (sel < 65) begin
        pkt = new[5];
        pkt[0] = LEAD_END;
        for (int i = 1; i < 5; i++) pkt[i] = 8'($urandom);
        send_packet(pkt);
      end else if (sel < 75) begin
        pkt = new[$urandom_range(1, 8)];
        pkt[0] = LEAD_ERROR;
        for (int i = 1; i < pkt.size(); i++) pkt[i] = 8'($urandom);
        send_packet(pkt);
      end else begin
        pkt = new[$urandom_range(1, 12)];
        for (int i = 0; i < pkt.size(); i++) pkt[i] = 8'($urandom);
        send_packet(pkt);
      end
    end
  endtask

  logic [7:0] dpkt[];

  initial begin
    sb = new();
    rst = 1;
    in_valid = 0;
    packet_byte = 0;
    end_of_packet = 0;
    cfg_valid = 0;
    cfg_index = CFG_VERIFY;
    cfg_data = 0;
    out_ready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    byte_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed
    dpkt = new[5]; dpkt = '{8'd254, 8'hFF, 8'hFF, 8'h00, 8'h00}; send_packet(dpkt);
    dpkt = new[3]; dpkt = '{8'd255, 8'h34, 8'h12}; send_packet(dpkt);
    dpkt = new[1]; dpkt = '{8'd255}; send_packet(dpkt);
    dpkt = new[2]; dpkt = '{8'd0, 8'hFF}; send_packet(dpkt);
    send_event(8'd2, 3, 1'b0, 1'b1, 1'b1, 64'd0, 0);
    send_event(8'd2, 0, 1'b0, 1'b0, 1'b1, 64'd0, 0);
    drain();
    write_reg(CFG_VERIFY, 64'd1);
    write_reg(CFG_TEXT, 64'h3030_3030_362E_352E);
    write_reg(CFG_CHARS, 64'd8);
    write_reg(CFG_FORMAT, 64'd15);
    send_event(8'd15, 14, 1'b1, 1'b1, 1'b1, 64'h3030_3030_372E_352E, 8);
    send_event(8'd15, 14, 1'b1, 1'b1, 1'b1, 64'h3030_3030_362E_352E, 8);
    send_event(8'd4, 2, 1'b1, 1'b1, 1'b0, 64'd0, 0);
    send_event(8'd4, 0, 1'b1, 1'b1, 1'b1, 64'd0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      if (ph == 4) begin
        write_reg(CFG_TEXT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_CHARS, 64'd15);
        write_reg(CFG_VERIFY, 64'd0);
        write_reg(CFG_FORMAT, 64'd255);
      end else if (ph == 5) begin
        write_reg(CFG_TEXT, 64'd0);
        write_reg(CFG_CHARS, 64'd1);
        write_reg(CFG_FORMAT, 64'd0);
      end else if (ph > 0) random_config();
      random_traffic(65);
      drain();
    end

    recv_stall_pct = 0;
    drain();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("binlog_event_packet_checker_unit_test: clean");
    else
      $display("binlog_event_packet_checker_unit_test: errors");
    $finish;
  end

endmodule
